>>> hw/rtl/fiso_pkg.sv
// Package for the flat index to segment offset block.
// Holds item kind and status codes, default sizes and the controller/datapath
// command and status structs. No dependencies.
`default_nettype none

package fiso_pkg;

  localparam int unsigned DefaultMaxSegments  = 1024;
  localparam int unsigned DefaultPositionBits = 48;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BEYOND = 2'd1,
    STATUS_FULL   = 2'd2,
    STATUS_BELOW  = 2'd3
  } status_e;

  typedef struct packed {
    logic capture;  // latch the input item
    logic finish;   // apply a non-scan item and write its result
    logic step;     // advance the cursor by one segment
    logic hit;      // write the result of a successful query
  } cmd_t;

  typedef struct packed {
    logic enter_scan;  // captured item is a query that passed its checks
    logic advance;     // position lies past the current segment's end
    logic out_free;    // result register can take a new result
  } stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/fiso_ctrl.sv
// Controller state machine for the flat index to segment offset block.
// Sequences capture, execution and the cursor scan. Depends on fiso_pkg.
`default_nettype none

module fiso_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire fiso_pkg::stat_t stat_i,
  output fiso_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_SCAN = 3'b100
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat_i.enter_scan) begin
          state_d = ST_SCAN;
        end else if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (stat_i.advance) begin
          cmd_o.step = 1'b1;
        end else if (stat_i.out_free) begin
          cmd_o.hit = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fiso_datapath.sv
// Datapath for the flat index to segment offset block: segment end table,
// running total, count, cursor, base and the result register. Depends on fiso_pkg.
`default_nettype none

module fiso_datapath #(
  parameter int unsigned MAX_SEGMENTS  = fiso_pkg::DefaultMaxSegments,
  parameter int unsigned POSITION_BITS = fiso_pkg::DefaultPositionBits,
  localparam int unsigned CntW = $clog2(MAX_SEGMENTS + 1),
  localparam int unsigned IdxW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [1:0]               kind_i,
  input  wire logic [POSITION_BITS-1:0] value_i,
  input  wire logic                     out_ready_i,
  output logic                          out_valid_o,
  output logic [CntW-1:0]               segment_number_o,
  output logic [POSITION_BITS-1:0]      offset_o,
  output logic [1:0]                    status_o,
  input  wire fiso_pkg::cmd_t           cmd_i,
  output fiso_pkg::stat_t               stat_o
);

  localparam int unsigned PosW = POSITION_BITS;

  logic [PosW-1:0] seg_end_mem [MAX_SEGMENTS];

  fiso_pkg::kind_e kind_q;
  logic [PosW-1:0] value_q;
  logic [CntW-1:0] count_q;
  logic [PosW-1:0] total_q;
  logic [IdxW-1:0] cursor_q;
  logic [PosW-1:0] base_q;
  logic [PosW-1:0] rd_q;

  logic            out_valid_q;
  logic [CntW-1:0] seg_num_q, seg_num_d;
  logic [PosW-1:0] offset_q, offset_d;
  logic [1:0]      status_q, status_d;

  logic [PosW:0]   sum_w;
  logic [PosW-1:0] sat_sum;
  logic            full;
  logic            beyond;
  logic            below;
  logic            load_ok;
  logic [CntW-1:0] cursor_ext;
  logic [CntW-1:0] cursor_inc;
  logic [IdxW-1:0] raddr;

  assign sum_w      = {1'b0, total_q} + {1'b0, value_q};
  assign sat_sum    = sum_w[PosW] ? {PosW{1'b1}} : sum_w[PosW-1:0];
  assign full       = (count_q == CntW'(MAX_SEGMENTS));
  assign beyond     = (count_q == '0) || (value_q > total_q);
  assign below      = (value_q <= base_q);
  assign load_ok    = cmd_i.finish && (kind_q == fiso_pkg::KIND_LOAD) && !full;
  assign cursor_ext = CntW'(cursor_q);
  assign cursor_inc = cursor_ext + 1'b1;
  assign raddr      = cmd_i.step ? IdxW'(cursor_inc) : cursor_q;

  assign stat_o.enter_scan = (kind_q == fiso_pkg::KIND_QUERY) && !beyond && !below;
  assign stat_o.advance    = (cursor_inc < count_q) && (value_q > rd_q);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // Segment end table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      seg_end_mem[count_q[IdxW-1:0]] <= sat_sum;
    end
    rd_q <= seg_end_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= fiso_pkg::kind_e'(kind_i);
      value_q <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      total_q  <= '0;
      cursor_q <= '0;
      base_q   <= '0;
    end else if (load_ok) begin
      count_q <= count_q + 1'b1;
      total_q <= sat_sum;
    end else if (cmd_i.finish && (kind_q == fiso_pkg::KIND_CLEAR)) begin
      count_q  <= '0;
      total_q  <= '0;
      cursor_q <= '0;
      base_q   <= '0;
    end else if (cmd_i.step) begin
      cursor_q <= IdxW'(cursor_inc);
      base_q   <= rd_q;
    end
  end

  always_comb begin
    seg_num_d = '0;
    offset_d  = '0;
    status_d  = fiso_pkg::STATUS_OK;
    if (cmd_i.hit) begin
      seg_num_d = cursor_inc;
      offset_d  = value_q - base_q;
    end else begin
      case (kind_q)
        fiso_pkg::KIND_LOAD: begin
          if (full) begin
            status_d = fiso_pkg::STATUS_FULL;
          end else begin
            seg_num_d = count_q + 1'b1;
          end
        end
        fiso_pkg::KIND_QUERY: begin
          status_d = beyond ? fiso_pkg::STATUS_BEYOND : fiso_pkg::STATUS_BELOW;
        end
        default: begin
          status_d = fiso_pkg::STATUS_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish || cmd_i.hit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish || cmd_i.hit) begin
      seg_num_q <= seg_num_d;
      offset_q  <= offset_d;
      status_q  <= status_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign segment_number_o = seg_num_q;
  assign offset_o         = offset_q;
  assign status_o         = status_q;

endmodule

`default_nettype wire

>>> hw/rtl/flat_index_to_segment_offset.sv
// Loads, clears, rejected queries and unknown kinds are captured, then finished with
// their result registered once the result register is free; a successful query first
// scans the cursor forward, then writes its result likewise. A new item is taken only
// after the last result is written; the cursor scan reads one table entry per cycle
// through the single read port. Reset clears count, running total, cursor and handshake
// state; the segment end table is not cleared and only its entries below the count are used.
`default_nettype none

module flat_index_to_segment_offset #(
  parameter int unsigned MAX_SEGMENTS  = fiso_pkg::DefaultMaxSegments,
  parameter int unsigned POSITION_BITS = fiso_pkg::DefaultPositionBits,
  localparam int unsigned CntW = $clog2(MAX_SEGMENTS + 1)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [1:0]               kind_i,
  input  wire logic [POSITION_BITS-1:0] value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [CntW-1:0]               segment_number_o,
  output logic [POSITION_BITS-1:0]      offset_o,
  output logic [1:0]                    status_o
);

  fiso_pkg::cmd_t  cmd;
  fiso_pkg::stat_t stat;

  fiso_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fiso_datapath #(
    .MAX_SEGMENTS  (MAX_SEGMENTS),
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .kind_i           (kind_i),
    .value_i          (value_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .segment_number_o (segment_number_o),
    .offset_o         (offset_o),
    .status_o         (status_o),
    .cmd_i            (cmd),
    .stat_o           (stat)
  );

endmodule

`default_nettype wire

>>> dv/tb.sv
// Testbench for flat_index_to_segment_offset: drives append, query, clear and unknown
// items through the valid/ready handshake and checks every result against a scoreboard.
// Depends on fiso_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MaxSeg = fiso_pkg::DefaultMaxSegments;
  localparam int unsigned PosW   = fiso_pkg::DefaultPositionBits;
  localparam int unsigned SegW   = $clog2(MaxSeg + 1);

  typedef struct packed {
    logic [SegW-1:0]   seg;
    logic [PosW-1:0]   off;
    fiso_pkg::status_e st;
  } lookup_answer_t;

  class segment_lookup_board;
    logic [PosW-1:0] seg_end [MaxSeg];
    int unsigned     seg_count;
    logic [PosW-1:0] total;
    int unsigned     cursor;
    lookup_answer_t  pending_answers [$];
    int unsigned     errors;

    function new();
      clear_table();
      errors = 0;
    endfunction

    function void clear_table();
      seg_count = 0;
      total     = '0;
      cursor    = 0;
    endfunction

    // Work out the answer to one accepted item and queue it.
    function void note_transfer(fiso_pkg::kind_e kind, logic [PosW-1:0] value);
      lookup_answer_t ans;
      logic [PosW:0]   sum;
      logic [PosW-1:0] base;
      ans    = '0;
      ans.st = fiso_pkg::STATUS_OK;
      case (kind)
        fiso_pkg::KIND_LOAD: begin
          if (seg_count >= MaxSeg) begin
            ans.st = fiso_pkg::STATUS_FULL;
          end else begin
            sum   = {1'b0, total} + {1'b0, value};
            total = sum[PosW] ? '1 : sum[PosW-1:0];
            seg_end[seg_count] = total;
            seg_count++;
            ans.seg = SegW'(seg_count);
          end
        end
        fiso_pkg::KIND_QUERY: begin
          if (seg_count == 0 || value > total) begin
            ans.st = fiso_pkg::STATUS_BEYOND;
          end else begin
            if (cursor >= seg_count) cursor = 0;
            base = (cursor == 0) ? '0 : seg_end[cursor-1];
            if (value == '0 || (cursor != 0 && value <= base)) begin
              ans.st = fiso_pkg::STATUS_BELOW;
            end else begin
              while (cursor + 1 < seg_count && value > seg_end[cursor]) cursor++;
              base    = (cursor == 0) ? '0 : seg_end[cursor-1];
              ans.seg = SegW'(cursor + 1);
              ans.off = value - base;
            end
          end
        end
        fiso_pkg::KIND_CLEAR: clear_table();
        default: ;
      endcase
      pending_answers = {pending_answers, ans};
    endfunction

    task report_mismatch(string msg);
      if (errors < 40) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [SegW-1:0] seg, logic [PosW-1:0] off, logic [1:0] st);
      lookup_answer_t want;
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected result seg %0d off %0d status %0d", seg, off, st));
      end else begin
        want = pending_answers.pop_front();
        if (seg !== want.seg)
          report_mismatch($sformatf("segment_number %0d, want %0d", seg, want.seg));
        if (off !== want.off)
          report_mismatch($sformatf("offset %0d, want %0d", off, want.off));
        if (st !== want.st)
          report_mismatch($sformatf("status %0d, want %0d", st, want.st));
      end
    endtask
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  logic [1:0]      kind_i;
  logic [PosW-1:0] value_i;
  logic            out_valid_o;
  logic            out_ready_i;
  logic [SegW-1:0] segment_number_o;
  logic [PosW-1:0] offset_o;
  logic [1:0]      status_o;

  segment_lookup_board lookup_board;
  bit          calm;
  int unsigned items_sent;

  always #6 clk_i = ~clk_i;

  flat_index_to_segment_offset dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .segment_number_o (segment_number_o),
    .offset_o         (offset_o),
    .status_o         (status_o)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PosW-1:0] rand_pos();
    return PosW'({$urandom, $urandom});
  endfunction

  function automatic logic [PosW-1:0] pick_size(int scale);
    case (scale)
      0:       return PosW'($urandom_range(0, 20));
      1:       return PosW'($urandom_range(0, 65535));
      default: return rand_pos() >> $urandom_range(0, PosW - 1);
    endcase
  endfunction

  task automatic send(fiso_pkg::kind_e kind, logic [PosW-1:0] value);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      kind_i     <= 2'($urandom);
      value_i    <= rand_pos();
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    lookup_board.note_transfer(kind, value);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (lookup_board.pending_answers.size() != 0) @(negedge clk_i);
  endtask

  // Nondecreasing positions, with segment boundaries and some noise mixed in.
  task automatic query_sweep(int nq, int scale);
    logic [63:0] pos, top, step, pick;
    int unsigned idx;
    pos = 0;
    for (int i = 0; i < nq; i++) begin
      top = {16'b0, lookup_board.total};
      if ($urandom_range(0, 99) < 8) begin
        case ($urandom_range(0, 4))
          0: send(fiso_pkg::KIND_NONE, rand_pos());
          1: send(fiso_pkg::KIND_QUERY, '0);
          2: begin
            if (lookup_board.total == '1) begin
              send(fiso_pkg::KIND_QUERY, rand_pos());
            end else begin
              pick = top + 1 + $urandom_range(0, 9);
              send(fiso_pkg::KIND_QUERY,
                   (pick > {16'b0, {PosW{1'b1}}}) ? '1 : PosW'(pick));
            end
          end
          3: send(fiso_pkg::KIND_QUERY,
                  (pos == 0) ? '0 : PosW'(pos - 1 - ({$urandom, $urandom} % pos)));
          default: send(fiso_pkg::KIND_LOAD, pick_size(scale));
        endcase
      end else begin
        if ($urandom_range(0, 99) < 30 && lookup_board.seg_count > 0) begin
          idx  = $urandom_range(0, lookup_board.seg_count - 1);
          pick = {16'b0, lookup_board.seg_end[idx]} + $urandom_range(0, 1);
          if (pick >= pos && pick <= top) pos = pick;
        end else begin
          step = top / nq;
          pos  = pos + ({$urandom, $urandom} % (2 * step + 1));
          if (pos > top) pos = top;
        end
        if (pos == 0 && top != 0) pos = 1;
        send(fiso_pkg::KIND_QUERY, PosW'(pos));
      end
    end
  endtask

  task automatic run_batch();
    int scale, nseg;
    calm  = ($urandom_range(0, 3) == 0);
    scale = $urandom_range(0, 9);
    scale = (scale < 6) ? 0 : (scale < 8) ? 1 : 2;
    nseg  = $urandom_range(1, 12);
    if ($urandom_range(0, 9) == 0) wait_drained();
    send(fiso_pkg::KIND_CLEAR, rand_pos());
    for (int i = 0; i < nseg; i++) send(fiso_pkg::KIND_LOAD, pick_size(scale));
    query_sweep($urandom_range(1, 20), scale);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      lookup_board.check_result(segment_number_o, offset_o, status_o);
  end

  initial begin
    int stall;
    stall       = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    lookup_board = new();
    calm       = 1'b0;
    items_sent = 0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    kind_i     = fiso_pkg::KIND_NONE;
    value_i    = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, zero-size segment, boundaries, going backwards,
    // saturation of the running total, unknown kind, clear.
    send(fiso_pkg::KIND_QUERY, PosW'(5));
    send(fiso_pkg::KIND_NONE, '1);
    send(fiso_pkg::KIND_LOAD, '0);
    send(fiso_pkg::KIND_QUERY, PosW'(1));
    send(fiso_pkg::KIND_LOAD, PosW'(10));
    send(fiso_pkg::KIND_QUERY, '0);
    send(fiso_pkg::KIND_QUERY, PosW'(1));
    send(fiso_pkg::KIND_QUERY, PosW'(10));
    send(fiso_pkg::KIND_LOAD, PosW'(5));
    send(fiso_pkg::KIND_QUERY, PosW'(11));
    send(fiso_pkg::KIND_QUERY, PosW'(10));
    send(fiso_pkg::KIND_QUERY, PosW'(16));
    send(fiso_pkg::KIND_LOAD, '1);
    send(fiso_pkg::KIND_LOAD, PosW'(1));
    send(fiso_pkg::KIND_LOAD, '1);
    send(fiso_pkg::KIND_QUERY, '1);
    send(fiso_pkg::KIND_QUERY, '1);
    send(fiso_pkg::KIND_CLEAR, rand_pos());
    send(fiso_pkg::KIND_QUERY, PosW'(1));
    send(fiso_pkg::KIND_NONE, '0);
    send(fiso_pkg::KIND_CLEAR, '0);

    // Fill the table to the top, sweep it, then overfill.
    wait_drained();
    send(fiso_pkg::KIND_CLEAR, rand_pos());
    for (int i = 0; i < MaxSeg; i++) begin
      send(fiso_pkg::KIND_LOAD, PosW'($urandom_range(0, 3000)));
    end
    query_sweep(24, 0);
    send(fiso_pkg::KIND_QUERY, lookup_board.total);
    send(fiso_pkg::KIND_LOAD, PosW'($urandom_range(0, 20)));
    send(fiso_pkg::KIND_LOAD, '1);
    send(fiso_pkg::KIND_QUERY, lookup_board.total);

    while (items_sent < 1100) run_batch();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (lookup_board.pending_answers.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (lookup_board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
